// ===== rtl/ntc_pkg.sv =====
// ntc_pkg: types, constants and resistance table for the thermistor converter
// used by ntc_ctrl, ntc_dp and ntc_resistance_to_temperature; no dependencies
package ntc_pkg;

  localparam int TABLE_ENTRIES = 24;
  localparam int RES_W         = 20;
  localparam int ROM_W         = 16;
  localparam int TEMP_W        = 8;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int NUM_W         = ROM_W + 2;
  localparam int QUO_W         = 3;
  localparam int QK_W          = $clog2(QUO_W);

  localparam logic signed [TEMP_W-1:0] TEMP_BASE  = -8'sd10;
  localparam logic signed [TEMP_W-1:0] CLAMP_COLD = -8'sd9;
  localparam logic signed [TEMP_W-1:0] CLAMP_HOT  = 8'sd105;

  localparam logic [IDX_W-1:0] IDX_LAST      = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [IDX_W-1:0] IDX_LAST_PAIR = IDX_W'(TABLE_ENTRIES - 2);
  localparam logic [QK_W-1:0]  QK_TOP        = QK_W'(QUO_W - 1);

  // resistance in ohms, one entry every 5 degrees from -10 upward
  localparam logic [ROM_W-1:0] NTC_ROM [TABLE_ENTRIES] = '{
    16'd51820, 16'd40450, 16'd31770, 16'd24940, 16'd19680, 16'd15620,
    16'd12470, 16'd10000, 16'd8064,  16'd6538,  16'd5327,  16'd4363,
    16'd3592,  16'd2972,  16'd2472,  16'd2066,  16'd1735,  16'd1465,
    16'd1243,  16'd1059,  16'd908,   16'd781,   16'd674,   16'd585
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SEARCH,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } ntc_state_t;

  typedef struct packed {
    logic load;
    logic check;
    logic search_step;
    logic prep;
    logic div_step;
    logic write_out;
  } ntc_cmd_t;

  typedef struct packed {
    logic clamp;
    logic search_done;
    logic div_done;
  } ntc_sts_t;

endpackage

// ===== rtl/ntc_resistance_to_temperature.sv =====
// ntc_resistance_to_temperature: thermistor resistance to whole-degree celsius
// an input goes through the range check and then, when the reading is out of
// table range, to the output register, otherwise through bisection, prep and division
// one transaction in flight at a time; the next input is accepted only once the
// previous result is written to the output register, which waits on out_ready
// synchronous reset clears the state machine and out_valid; depends on ntc_pkg
module ntc_resistance_to_temperature (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ntc_pkg::RES_W-1:0]         resistance_ohms,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [ntc_pkg::TEMP_W-1:0] temperature_c
);
  import ntc_pkg::*;

  ntc_cmd_t cmd;
  ntc_sts_t sts;

  ntc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ntc_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .resistance_ohms (resistance_ohms),
    .temperature_c   (temperature_c)
  );

endmodule

// ===== rtl/ntc_ctrl.sv =====
// ntc_ctrl: sequencing state machine and output valid flag for the converter
// depends on ntc_pkg
module ntc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  ntc_pkg::ntc_sts_t sts,
  output ntc_pkg::ntc_cmd_t cmd
);
  import ntc_pkg::*;

  ntc_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.write_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.check  = 1'b1;
        state_next = sts.clamp ? ST_DONE : ST_SEARCH;
      end
      ST_SEARCH: begin
        if (sts.search_done) begin
          state_next = ST_PREP;
        end else begin
          cmd.search_step = 1'b1;
        end
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.write_out = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_accept_to_check: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_CHECK))
    else $error("accepted transaction did not start a range check");

  a_prep_to_div: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PREP) |=> (state == ST_DIV))
    else $error("division not started after operand preparation");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.write_out |-> (!out_valid || out_ready))
    else $error("output register overwritten while a result is pending");

endmodule

// ===== rtl/ntc_dp.sv =====
// ntc_dp: range check, table bisection, three-step restoring division and
// output register; depends on ntc_pkg
module ntc_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  ntc_pkg::ntc_cmd_t                   cmd,
  output ntc_pkg::ntc_sts_t                   sts,
  input  logic [ntc_pkg::RES_W-1:0]           resistance_ohms,
  output logic signed [ntc_pkg::TEMP_W-1:0]   temperature_c
);
  import ntc_pkg::*;

  logic [RES_W-1:0]         res;
  logic [IDX_W-1:0]         lo, hi;
  logic [NUM_W-1:0]         num;
  logic [ROM_W-1:0]         den;
  logic [QK_W-1:0]          k;
  logic [QUO_W-1:0]         quot;
  logic signed [TEMP_W-1:0] base;
  logic signed [TEMP_W-1:0] clamp_val;
  logic                     clamp;

  logic                     cold, hot;
  logic [IDX_W:0]           mid_sum;
  logic [IDX_W-1:0]         mid;
  logic [IDX_W-1:0]         idx;
  logic [ROM_W-1:0]         bot, top, diff;
  logic [NUM_W-1:0]         num_init;
  logic [NUM_W-1:0]         den_sh;
  logic [TEMP_W-1:0]        idx_x5;
  logic signed [TEMP_W-1:0] temp_calc;

  assign cold     = res > RES_W'(NTC_ROM[0]);
  assign hot      = res < RES_W'(NTC_ROM[IDX_LAST]);
  assign mid_sum  = {1'b0, lo} + {1'b0, hi};
  assign mid      = mid_sum[IDX_W:1];
  assign idx      = (lo > IDX_LAST_PAIR) ? IDX_LAST_PAIR : lo;
  assign bot      = NTC_ROM[idx];
  assign top      = NTC_ROM[idx + 1'b1];
  assign diff     = bot - res[ROM_W-1:0];
  assign num_init = {diff, 2'b00} + {2'b00, diff};
  assign den_sh   = NUM_W'(den) << k;
  assign idx_x5   = TEMP_W'({idx, 2'b00}) + TEMP_W'(idx);
  assign temp_calc = clamp ? clamp_val : (base + $signed(TEMP_W'(quot)));

  assign sts.clamp       = cold || hot;
  assign sts.search_done = (mid == lo);
  assign sts.div_done    = (k == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      clamp <= 1'b0;
    end else if (cmd.check) begin
      clamp <= cold || hot;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res <= resistance_ohms;
    end
    if (cmd.check) begin
      lo        <= '0;
      hi        <= IDX_LAST;
      clamp_val <= cold ? CLAMP_COLD : CLAMP_HOT;
    end
    if (cmd.search_step) begin
      if (RES_W'(NTC_ROM[mid]) >= res) begin
        lo <= mid;
      end else begin
        hi <= mid;
      end
    end
    if (cmd.prep) begin
      num  <= num_init;
      den  <= bot - top;
      k    <= QK_TOP;
      quot <= '0;
      base <= TEMP_BASE + $signed(idx_x5);
    end
    if (cmd.div_step) begin
      if (num >= den_sh) begin
        num     <= num - den_sh;
        quot[k] <= 1'b1;
      end
      k <= k - 1'b1;
    end
    if (cmd.write_out) begin
      temperature_c <= temp_calc;
    end
  end

  a_load_capture: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (res == $past(resistance_ohms)))
    else $error("input transaction not captured");

  a_quot_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.write_out && !clamp) |-> (quot <= QUO_W'(5)))
    else $error("interpolation step exceeds one table interval");

  a_bracket: assert property (@(posedge clk) disable iff (rst)
    cmd.prep |-> (bot > top))
    else $error("bracketing entries out of order");

endmodule

// ===== bench/ntc_temperature_checker.sv =====
// ntc_temperature_checker: watches the input and output of the thermistor converter,
// predicts each temperature from the accepted resistance and compares results
// depends on ntc_pkg for widths, clamp values and the resistance table
module ntc_temperature_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [ntc_pkg::RES_W-1:0]         resistance_ohms,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic signed [ntc_pkg::TEMP_W-1:0] temperature_c,
  output int                                fail_count,
  output int                                outstanding,
  output int                                compared
);
  timeunit 1ns;
  timeprecision 1ps;
  import ntc_pkg::*;

  localparam int unsigned TEMP_STEP = 5;

  typedef struct {
    logic [RES_W-1:0]         ohms;
    logic signed [TEMP_W-1:0] degrees;
  } reading_t;

  reading_t expected_q[$];

  function automatic logic signed [TEMP_W-1:0] expected_temperature(
    logic [RES_W-1:0] ohms
  );
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    int unsigned upper;
    int unsigned lower;
    int unsigned frac;
    int          degrees;
    if (ohms > NTC_ROM[0]) return CLAMP_COLD;
    if (ohms < NTC_ROM[TABLE_ENTRIES-1]) return CLAMP_HOT;
    // bisection keeps the upper-resistance side of the bracket in lo
    lo = 0;
    hi = TABLE_ENTRIES - 1;
    mid = (lo + hi) / 2;
    while (mid != lo) begin
      if (NTC_ROM[mid] >= ohms) lo = mid;
      else hi = mid;
      mid = (lo + hi) / 2;
    end
    if (lo > TABLE_ENTRIES - 2) lo = TABLE_ENTRIES - 2;
    upper = NTC_ROM[lo];
    lower = NTC_ROM[lo+1];
    frac = 0;
    if (upper > lower && upper >= ohms)
      frac = (TEMP_STEP * (upper - ohms)) / (upper - lower);
    degrees = int'(TEMP_BASE) + int'(TEMP_STEP * lo) + int'(frac);
    return TEMP_W'(degrees);
  endfunction

  always @(posedge clk) begin
    reading_t got;
    if (!rst) begin
      if (in_valid && in_ready)
        expected_q.push_back('{resistance_ohms, expected_temperature(resistance_ohms)});
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, got %0d", $time, temperature_c);
          fail_count = fail_count + 1;
        end else begin
          got = expected_q.pop_front();
          compared = compared + 1;
          if (temperature_c !== got.degrees) begin
            $display("%0t: temperature for %0d ohms: expected %0d, got %0d",
                     $time, got.ohms, got.degrees, temperature_c);
            fail_count = fail_count + 1;
          end
        end
      end
      outstanding = expected_q.size();
    end
  end

endmodule

// ===== bench/ntc_resistance_to_temperature_tb.sv =====
// ntc_resistance_to_temperature_tb: drives directed and random resistance readings
// with random gaps and output stalls, checks results through ntc_temperature_checker
// depends on ntc_pkg, ntc_resistance_to_temperature and ntc_temperature_checker
module ntc_resistance_to_temperature_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ntc_pkg::*;

  localparam int RANDOM_READINGS = 1800;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int SETTLE_CYCLES   = 20;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [RES_W-1:0]         resistance_ohms = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [TEMP_W-1:0] temperature_c;

  int fail_count;
  int outstanding;
  int compared;
  int cycles = 0;
  int sent = 0;
  int above_table = 0;
  int below_table = 0;
  int on_entry = 0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  int rx_stall = 0;

  always #5 clk = ~clk;

  ntc_resistance_to_temperature uut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .resistance_ohms (resistance_ohms),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .temperature_c   (temperature_c)
  );

  ntc_temperature_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .resistance_ohms (resistance_ohms),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .temperature_c   (temperature_c),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .compared        (compared)
  );

  function automatic int idle_cycles();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [RES_W-1:0] random_reading();
    int pick;
    int idx;
    pick = $urandom_range(0, 99);
    idx = $urandom_range(0, TABLE_ENTRIES - 1);
    if (pick < 15) return RES_W'(NTC_ROM[idx]);
    if (pick < 30) return RES_W'(int'(NTC_ROM[idx]) + $urandom_range(0, 4) - 2);
    if (pick < 75) return RES_W'($urandom_range(NTC_ROM[TABLE_ENTRIES-1], NTC_ROM[0]));
    if (pick < 85) return RES_W'($urandom_range(0, NTC_ROM[TABLE_ENTRIES-1] - 1));
    if (pick < 95) return RES_W'($urandom_range(NTC_ROM[0] + 1, (1 << RES_W) - 1));
    return RES_W'($urandom);
  endfunction

  // output side: random stalls, with calm stretches that start no new stalls
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) rx_calm = !rx_calm;
    if (rx_stall > 0) begin
      out_ready <= 1'b0;
      rx_stall = rx_stall - 1;
    end else begin
      out_ready <= 1'b1;
      if (!rx_calm && $urandom_range(0, 99) < 30) rx_stall = idle_cycles();
    end
  end

  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: no progress after %0d cycles", $time, cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_reading(logic [RES_W-1:0] ohms);
    int gap;
    gap = tx_calm ? 0 : idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    resistance_ohms <= ohms;
    do @(posedge clk); while (!in_ready);
    sent = sent + 1;
    if (ohms > NTC_ROM[0]) above_table = above_table + 1;
    if (ohms < NTC_ROM[TABLE_ENTRIES-1]) below_table = below_table + 1;
    for (int i = 0; i < TABLE_ENTRIES; i++) if (ohms == NTC_ROM[i]) on_entry = on_entry + 1;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  initial begin
    logic [RES_W-1:0] directed[$];
    directed = {20'd0, 20'd584, 20'd585, 20'd586, 20'd673, 20'd674, 20'd675,
                20'd5327, 20'd10000, 20'd12345, 20'd40450, 20'd51819, 20'd51820,
                20'd51821, 20'd65535, 20'd65536, 20'd524288, 20'hFFFFE,
                20'hFFFFF, 20'h55555, 20'hAAAAA};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    tx_calm = 1'b1;
    foreach (directed[i]) send_reading(directed[i]);
    drain();

    for (int n = 0; n < RANDOM_READINGS; n++) begin
      if (n % 150 == 0) tx_calm = ($urandom_range(0, 3) == 0);
      if (n == RANDOM_READINGS / 2) drain();
      send_reading(random_reading());
    end
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("%0d readings sent, %0d temperatures compared", sent, compared);
    $display("%0d above the table, %0d below it, %0d exactly on an entry",
             above_table, below_table, on_entry);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
